/* sv/tcf_pkg.sv */
`timescale 1ns / 1ps
package tcf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Wide enough to count the largest supported number of CORDIC steps.
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 8'd1;

  localparam logic [16:0] BLEND_WEIGHT_RST = 17'd58982;
  localparam logic [14:0] TOLERANCE_RST    = 15'd2458;
  localparam logic [16:0] ALPHA_ONE        = 17'd65536;
  localparam logic [15:0] ONE_G            = 16'd16384;
  localparam logic [17:0] GYRO_DIV         = 18'd131000;

  typedef struct packed {
    logic              load;
    logic              cinit;
    logic              cstep;
    logic              csave;
    logic              diff;
    logic              mul;
    logic              upd;
    logic              out_load;
    logic              axis;
    logic [STEP_W-1:0] step;
  } tcf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } tcf_status_t;

  // atan(2^-i) in degrees, Q.24.
  function automatic logic [29:0] atan_q24(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:    r = 30'd754974720;
      5'd1:    r = 30'd445687602;
      5'd2:    r = 30'd235489088;
      5'd3:    r = 30'd119537938;
      5'd4:    r = 30'd60000934;
      5'd5:    r = 30'd30029717;
      5'd6:    r = 30'd15018523;
      5'd7:    r = 30'd7509720;
      5'd8:    r = 30'd3754917;
      5'd9:    r = 30'd1877466;
      5'd10:   r = 30'd938734;
      5'd11:   r = 30'd469367;
      5'd12:   r = 30'd234684;
      5'd13:   r = 30'd117342;
      5'd14:   r = 30'd58671;
      5'd15:   r = 30'd29335;
      5'd16:   r = 30'd14668;
      5'd17:   r = 30'd7334;
      5'd18:   r = 30'd3667;
      5'd19:   r = 30'd1833;
      5'd20:   r = 30'd917;
      5'd21:   r = 30'd458;
      5'd22:   r = 30'd229;
      5'd23:   r = 30'd115;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/tcf_ctrl.sv */
`timescale 1ns / 1ps
module tcf_ctrl #(
  parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output tcf_pkg::tcf_cmd_t   cmd,
  input  tcf_pkg::tcf_status_t status
);
  import tcf_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CINIT = 9'b000000010,
    S_CSTEP = 9'b000000100,
    S_CSAVE = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_DIFF  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  state_t            state, state_next;
  logic              axis, axis_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid, out_valid_next;
  logic              out_load;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    step_next  = step;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        axis_next = 1'b0;
        if (s_tvalid) state_next = S_CINIT;
      end
      S_CINIT: begin
        step_next  = '0;
        state_next = S_CSTEP;
      end
      S_CSTEP: begin
        if (step == LAST_STEP) state_next = S_CSAVE;
        else step_next = step + 1'b1;
      end
      S_CSAVE: begin
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_CINIT;
        end else begin
          axis_next  = 1'b0;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!status.div_busy) state_next = S_DIFF;
      end
      S_DIFF: state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD: begin
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_DIFF;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && s_tvalid;
    cmd.cinit    = (state == S_CINIT);
    cmd.cstep    = (state == S_CSTEP);
    cmd.csave    = (state == S_CSAVE);
    cmd.diff     = (state == S_DIFF);
    cmd.mul      = (state == S_MUL);
    cmd.upd      = (state == S_UPD);
    cmd.out_load = out_load;
    cmd.axis     = axis;
    cmd.step     = step;
  end

`ifndef SYNTHESIS
  a_accept_starts_cordic: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (cmd.cinit && !axis))
    else $error("accepted beat did not start the pitch CORDIC run");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result register loaded while holding an untaken beat");
  a_filter_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.diff |-> !status.div_busy)
    else $error("filter started before gyro increments were ready");
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.cstep || cmd.upd) |-> !s_tready)
    else $error("input ready while an item is in flight");
`endif

endmodule

/* sv/tcf_datapath.sv */
`timescale 1ns / 1ps
module tcf_datapath #(
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [95:0]                       s_tdata,
  input  logic                              cfg_valid,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [23:0]                       m_tdata,
  input  tcf_pkg::tcf_cmd_t                 cmd,
  output tcf_pkg::tcf_status_t              status
);
  import tcf_pkg::*;

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int AW  = F + 11;   // stored angle
  localparam int QB  = F + 15;   // quotient bits of the gyro divider
  localparam int NW  = QB + 17;  // divider numerator
  localparam int IW  = QB + 1;   // signed gyro increment
  localparam int DW  = F + 18;   // predicted minus accel angle
  localparam int PW  = DW + 18;
  localparam int SW  = PW + 1;
  localparam int XW  = 36;
  localparam int ACW = 34;
  localparam int SH  = 24 - F;
  localparam int RW  = F + 16;   // reciprocal of the gyro divisor
  localparam int GW  = 31 + RW;  // magnitude times reciprocal

  localparam logic signed [ACW-1:0] DEG90   = ACW'(90 * (2 ** 24));
  localparam logic signed [ACW-1:0] ACC_RND = ACW'(2 ** (SH - 1));
  localparam logic signed [SW-1:0]  LIM     = SW'(1023 * (2 ** F));
  localparam logic [AW-1:0]         HALF    = AW'(2 ** (F - 1));
  localparam logic [RW-1:0]         RECIP   = RW'((64'd1 << (F + 32)) / 64'd131000);

  localparam logic [1:0] DIV_EST = 2'd3;
  localparam logic [1:0] DIV_REM = 2'd2;
  localparam logic [1:0] DIV_FIX = 2'd1;

  // Configuration.
  logic [16:0] blend_weight;
  logic [14:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= BLEND_WEIGHT_RST;
      tolerance    <= TOLERANCE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BLEND_WEIGHT) blend_weight <= cfg_data;
      else if (cfg_index == CFG_TOLERANCE) tolerance <= cfg_data[14:0];
    end
  end

  // Input fields.
  logic signed [15:0] in_ax, in_ay, in_az, in_gx, in_gy;
  logic        [15:0] in_ms;
  assign in_ax = s_tdata[15:0];
  assign in_ay = s_tdata[31:16];
  assign in_az = s_tdata[47:32];
  assign in_gx = s_tdata[63:48];
  assign in_gy = s_tdata[79:64];
  assign in_ms = s_tdata[95:80];

  logic signed [15:0] ax, ay, az;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= in_ax;
      ay <= in_ay;
      az <= in_az;
    end
  end

  // Magnitude test, free running on the held sample.
  logic signed [31:0] px, py, pz;
  logic        [30:0] sq_x, sq_y, sq_z;
  logic        [15:0] hi;
  logic        [14:0] lo;
  logic        [31:0] hh;
  logic        [29:0] ll;
  logic               lo_void;
  logic        [32:0] mag_sq;
  logic               reliable;

  assign px      = ax * ax;
  assign py      = ay * ay;
  assign pz      = az * az;
  assign hi      = ONE_G + {1'b0, tolerance};
  assign lo      = ONE_G[14:0] - tolerance;
  assign lo_void = (tolerance >= ONE_G[14:0]);
  assign mag_sq  = {2'b0, sq_x} + {2'b0, sq_y} + {2'b0, sq_z};

  always_ff @(posedge clk) begin
    sq_x     <= px[30:0];
    sq_y     <= py[30:0];
    sq_z     <= pz[30:0];
    hh       <= hi * hi;
    ll       <= {15'b0, lo} * {15'b0, lo};
    reliable <= (mag_sq < {1'b0, hh}) && (lo_void || (mag_sq > {3'b0, ll}));
  end

  // Gyro increment: |gyro*ms|*2^F/131000 by reciprocal multiplication. The estimate is
  // at most one below the true quotient, so a single compare and add finishes it.
  // Lane 0 integrates pitch from gyro_y, lane 1 roll from gyro_x.
  logic signed [32:0]   gprod [2];
  logic        [32:0]   gabs  [2];
  logic        [30:0]   gmag  [2];
  logic        [NW-1:0] gnum  [2];
  logic        [GW-1:0] gq    [2];
  logic        [NW-1:0] gsub  [2];
  logic        [QB-1:0] qest  [2];
  logic        [17:0]   qrem  [2];
  logic        [QB-1:0] dnq   [2];
  logic                 dneg  [2];
  logic        [1:0]    div_cnt;
  logic signed [IW-1:0] inc [2];

  assign gprod[0] = in_gy * $signed({1'b0, in_ms});
  assign gprod[1] = in_gx * $signed({1'b0, in_ms});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      gabs[l] = gprod[l][32] ? 33'(-gprod[l]) : 33'(gprod[l]);
      gnum[l] = NW'({gmag[l], {F{1'b0}}}) + NW'(65500);
      gq[l]   = GW'(gmag[l]) * GW'(RECIP);
      gsub[l] = gnum[l] - NW'(qest[l]) * NW'(GYRO_DIV);
      inc[l]  = dneg[l] ? -$signed({1'b0, dnq[l]}) : $signed({1'b0, dnq[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.load) begin
      div_cnt <= DIV_EST;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.load) begin
        gmag[l] <= gabs[l][30:0];
        dneg[l] <= gprod[l][32];
      end
      if (div_cnt == DIV_EST) qest[l] <= gq[l][GW-1:32];
      if (div_cnt == DIV_REM) qrem[l] <= gsub[l][17:0];
      if (div_cnt == DIV_FIX) dnq[l] <= qest[l] + QB'(qrem[l] >= GYRO_DIV);
    end
  end

  assign status.div_busy = (div_cnt != '0);

  // Vectoring CORDIC, shared by the pitch and roll runs.
  logic signed [15:0]     c_num;
  logic signed [XW-1:0]   xs, ys, x0, y0;
  logic signed [ACW-1:0]  acc0;
  logic signed [XW-1:0]   cx, cy, dx, dy;
  logic signed [ACW-1:0]  cacc, tab, acc_rnd;
  logic                   czero;
  logic signed [AW-1:0]   cang [2];

  assign c_num = cmd.axis ? ay : ax;
  assign xs    = {{(XW-32){az[15]}}, az, 16'h0};
  assign ys    = {{(XW-32){c_num[15]}}, c_num, 16'h0};
  assign dx    = cy >>> cmd.step;
  assign dy    = cx >>> cmd.step;
  assign tab   = $signed({4'b0, atan_q24(cmd.step)});
  assign acc_rnd = (cacc + ACC_RND) >>> SH;

  always_comb begin
    x0   = xs;
    y0   = ys;
    acc0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0   = ys;
        y0   = -xs;
        acc0 = DEG90;
      end else begin
        x0   = -ys;
        y0   = xs;
        acc0 = -DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      cx    <= x0;
      cy    <= y0;
      cacc  <= acc0;
      czero <= (az == 0) && (c_num == 0);
    end else if (cmd.cstep) begin
      if (cy > 0) begin
        cx   <= cx + dx;
        cy   <= cy - dy;
        cacc <= cacc + tab;
      end else begin
        cx   <= cx - dx;
        cy   <= cy + dy;
        cacc <= cacc - tab;
      end
    end
    if (cmd.csave) begin
      cang[cmd.axis] <= czero ? '0 : acc_rnd[AW-1:0];
    end
  end

  // Blend: 65536*accel + alpha*(predicted - accel), rounded, saturated.
  logic signed [AW-1:0] angle [2];
  logic signed [DW-1:0] diff_r;
  logic        [16:0]   alpha, alpha_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] bsum, bmag, bq, bres;

  assign alpha = (!reliable || (blend_weight > ALPHA_ONE)) ? ALPHA_ONE : blend_weight;

  always_comb begin
    bsum = SW'(prod_r) + (SW'(cang[cmd.axis]) <<< 16);
    bmag = (bsum < 0) ? -bsum : bsum;
    bq   = (bmag + SW'(32768)) >>> 16;
    bres = (bsum < 0) ? -bq : bq;
    if (bres > LIM) bres = LIM;
    else if (bres < -LIM) bres = -LIM;
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff_r  <= DW'(angle[cmd.axis]) + DW'(inc[cmd.axis]) - DW'(cang[cmd.axis]);
      alpha_r <= alpha;
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, alpha_r}) * diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle[0] <= '0;
      angle[1] <= '0;
    end else if (cmd.upd) begin
      angle[cmd.axis] <= bres[AW-1:0];
    end
  end

  // Whole degrees, rounded half away from zero.
  logic [AW-1:0] amag [2];
  logic [AW-1:0] adeg [2];
  logic [10:0]   deg  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      amag[l] = (angle[l] < 0) ? AW'(-angle[l]) : AW'(angle[l]);
      adeg[l] = (amag[l] + HALF) >> F;
      deg[l]  = (angle[l] < 0) ? 11'(-adeg[l][10:0]) : adeg[l][10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0, reliable, deg[0], deg[1]};
    end
  end

endmodule

/* sv/tilt_complementary_filter.sv */
`timescale 1ns / 1ps
// A result reaches m_tvalid after the pitch and roll CORDIC runs, a divider wait, a blend
// of each axis and the output load; the gyro increments come from an estimate, remainder and
// fix divider and are always ready in time. One item is in flight at a time, on one shared
// CORDIC unit; a new beat is taken while the previous result waits in m_tdata, and the output
// state stalls until a held result is taken.
// Reset (rst, synchronous, active high) zeroes pitch and roll and restores both registers.
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms (16 bits each)
  input  logic [95:0]                    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // roll_deg[10:0], pitch_deg[21:11], accel_reliable[22], zero pad[23]
  output logic [23:0]                    m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcf_pkg::*;

  tcf_cmd_t    cmd;
  tcf_status_t status;

  assign cfg_ready = 1'b1;

  tcf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tcf_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* tb/sv/tb_tilt_complementary_filter.sv */
`timescale 1ns / 1ps
module tb_tilt_complementary_filter;
  import tcf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [10:0] roll;
    logic [10:0] pitch;
    logic        reliable;
  } tilt_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: angles in degrees with 16 fraction bits.
  longint    pitch_q, roll_q;
  longint    weight_reg, tol_reg;
  tilt_out_t tilt_q[$];
  int        errors = 0;
  int        src_idle = 0;
  int        snk_idle = 0;
  int        hold_len = 0;

  longint atan_deg_q24[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                               30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                               469367, 234684, 117342, 58671, 29335};

  tilt_complementary_filter i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint tilt_atan2(longint yn, longint xd);
    longint x, y, acc, t, dx, dy;
    x = xd * 65536;
    y = yn * 65536;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = longint'(90) << 24;
      end else begin
        x = -y; y = t; acc = -(longint'(90) << 24);
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; acc += atan_deg_q24[i];
      end else begin
        x -= dx; y += dy; acc -= atan_deg_q24[i];
      end
    end
    return (acc + 128) >>> 8;
  endfunction

  function automatic longint round_away_div(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint blend_axis(longint angle, longint rate, longint ms,
                                        longint acc_angle, longint alpha);
    longint lim, pred, r;
    lim = longint'(1023) << 16;
    pred = angle + round_away_div(rate * ms * 65536, 131000);
    r = round_away_div(alpha * pred + (65536 - alpha) * acc_angle, 65536);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [10:0] whole_deg(longint a);
    longint m, q;
    m = (a < 0) ? -a : a;
    q = (m + 32768) >> 16;
    return (a < 0) ? 11'(-q) : 11'(q);
  endfunction

  function automatic tilt_out_t predict_tilt(logic [95:0] d);
    longint ax, ay, az, gx, gy, ms, s, hi, lo, alpha;
    tilt_out_t o;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    ms = longint'(d[95:80]);
    s = ax * ax + ay * ay + az * az;
    hi = 16384 + tol_reg;
    lo = 16384 - tol_reg;
    o.reliable = (s < hi * hi) && (lo <= 0 || s > lo * lo);
    alpha = (weight_reg > 65536 || !o.reliable) ? 65536 : weight_reg;
    pitch_q = blend_axis(pitch_q, gy, ms, tilt_atan2(ax, az), alpha);
    roll_q = blend_axis(roll_q, gx, ms, tilt_atan2(ay, az), alpha);
    o.roll = whole_deg(roll_q);
    o.pitch = whole_deg(pitch_q);
    return o;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    tilt_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (tilt_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_tdata);
        errors++;
      end else begin
        want = tilt_q.pop_front();
        if (m_tdata[10:0] !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time,
                   $signed(want.roll), $signed(m_tdata[10:0]));
          errors++;
        end
        if (m_tdata[21:11] !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time,
                   $signed(want.pitch), $signed(m_tdata[21:11]));
          errors++;
        end
        if (m_tdata[22] !== want.reliable) begin
          $display("%0t: reliable expected %0b actual %0b", $time,
                   want.reliable, m_tdata[22]);
          errors++;
        end
      end
    end
  end

  // Result sink, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_len--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // The ready line is looked at in the middle of the cycle, where it is settled.
  task automatic send_sample(logic [95:0] d);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    tilt_q.push_back(predict_tilt(d));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tilt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BLEND_WEIGHT) weight_reg = longint'(val);
    else if (idx == CFG_TOLERANCE) tol_reg = longint'(val[14:0]);
  endtask

  function automatic logic [95:0] pack_sample(int ax, int ay, int az, int gx, int gy,
                                              int ms);
    return {16'(ms), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  // Mostly a vector near 1 g in a random direction, sometimes anything at all.
  function automatic logic [95:0] random_sample();
    int  ax, ay, az, ms;
    real r2;
    if ($urandom_range(99) < 25)
      return {$urandom, $urandom, $urandom};
    ax = $urandom_range(24000) - 12000;
    ay = $urandom_range(20000) - 10000;
    r2 = 16384.0 * 16384.0 - real'(ax) * ax - real'(ay) * ay;
    az = (r2 > 0.0) ? int'($sqrt(r2)) : 0;
    if ($urandom_range(3) == 0) az = -az;
    az += $urandom_range(600) - 300;
    ms = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(40);
    return pack_sample(ax, ay, az, $urandom_range(65535) - 32768,
                       $urandom_range(8000) - 4000, ms);
  endfunction

  task automatic test_directed();
    send_sample(pack_sample(0, 0, 16384, 0, 0, 10));
    send_sample(pack_sample(0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, 65535));
    send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 65535));
    send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 65535));
    send_sample(pack_sample(16384, 0, 0, 0, 0, 1));
    send_sample(pack_sample(-16384, 0, 0, 0, 0, 1));
    send_sample(pack_sample(0, 16384, -100, 131, -131, 1000));
    send_sample(pack_sample(0, -16384, -100, -131, 131, 1000));
    send_sample(pack_sample(3000, -4000, -16000, 0, 0, 5));
    send_sample(pack_sample(-3000, 4000, -16000, 0, 0, 5));
    send_sample(pack_sample(0, 0, -16384, 0, 0, 5));
    send_sample(pack_sample(0, 0, 16384 + 2457, 0, 0, 5));
    send_sample(pack_sample(0, 0, 16384 + 2458, 0, 0, 5));
    send_sample(pack_sample(0, 0, 16384 - 2458, 0, 0, 5));
    send_sample(pack_sample(0, 0, 16384 - 2457, 0, 0, 5));
    send_sample(pack_sample(0, 0, 16384, 65, -65, 1));
    send_sample(pack_sample(0, 0, 16384, -66, 66, 1));
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) send_sample(random_sample());
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_BLEND_WEIGHT, 17'd0);
    random_burst(40);
    write_reg(CFG_BLEND_WEIGHT, 17'd65536);
    write_reg(CFG_TOLERANCE, 17'd0);
    random_burst(40);
    write_reg(CFG_BLEND_WEIGHT, 17'h1FFFF);
    write_reg(CFG_TOLERANCE, 17'd16384);
    random_burst(40);
    write_reg(CFG_TOLERANCE, 17'h1FFFF);
    write_reg(CFG_BLEND_WEIGHT, 17'd32768);
    random_burst(40);
    write_reg(CFG_UNUSED_IDX, 17'd5);
    write_reg(CFG_TOLERANCE, 17'd1);
    random_burst(40);
    write_reg(CFG_TOLERANCE, 17'd2458);
    write_reg(CFG_BLEND_WEIGHT, 17'd58982);
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    random_burst(30);
    wait_idle();
  endtask

  task automatic test_random_phases();
    src_idle = 17; snk_idle = 58;
    random_burst(500);
    wait_idle();
    src_idle = 58; snk_idle = 17;
    random_burst(500);
    src_idle = 0; snk_idle = 0;
    random_burst(550);
    s_tvalid <= 1'b0;
  endtask

  initial begin
    pitch_q = 0;
    roll_q = 0;
    weight_reg = 58982;
    tol_reg = 2458;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_phases();
    @(posedge clk);
    while (tilt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tilt_complementary_filter: match");
    end else begin
      $display("tilt_complementary_filter: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tilt_complementary_filter: mismatch");
    $finish;
  end

endmodule
